// File: design/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

  // Field and port widths
  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int INTEG_W  = 32;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int SUM_W    = 49;
  localparam int FRAC_W   = 8;

  // Default derivative bound
  localparam int DERIV_LIMIT_DEF = 50;

  // Reset values of the configuration registers
  localparam logic signed [SPEED_W-1:0] DRIVE_MIN_RST    = -16'sd100;
  localparam logic signed [SPEED_W-1:0] DRIVE_MAX_RST    = 16'sd100;
  localparam logic signed [INTEG_W-1:0] INTEGRAL_MIN_RST = -32'sd1000;
  localparam logic signed [INTEG_W-1:0] INTEGRAL_MAX_RST = 32'sd1000;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TARGET_SPEED = 3'd3,
    REG_DRIVE_MIN    = 3'd4,
    REG_DRIVE_MAX    = 3'd5,
    REG_INTEGRAL_MIN = 3'd6,
    REG_INTEGRAL_MAX = 3'd7
  } reg_idx_t;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] drive_min;
    logic signed [SPEED_W-1:0] drive_max;
    logic signed [INTEG_W-1:0] integral_min;
    logic signed [INTEG_W-1:0] integral_max;
  } cfg_t;

endpackage

// File: design/psc_in_if.sv
`timescale 1ns / 1ps

interface psc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psc_pkg::SPEED_W-1:0]   measured_speed;

  modport source (output valid, output measured_speed, input ready);
  modport sink   (input valid, input measured_speed, output ready);
endinterface

// File: design/psc_out_if.sv
`timescale 1ns / 1ps

interface psc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psc_pkg::SPEED_W-1:0]   drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

// File: design/psc_cfg_regs.sv
`timescale 1ns / 1ps

module psc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]    paddr,
  input  logic [psc_pkg::DATA_W-1:0]    pwdata,
  output logic [psc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output psc_pkg::cfg_t                 cfg
);

  psc_pkg::cfg_t    cfg_r;
  psc_pkg::reg_idx_t idx;
  logic             wr_en;

  // Registers are word aligned, so the index sits above the byte offset.
  assign idx    = psc_pkg::reg_idx_t'(paddr[psc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= '0;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.target_speed <= '0;
      cfg_r.drive_min    <= psc_pkg::DRIVE_MIN_RST;
      cfg_r.drive_max    <= psc_pkg::DRIVE_MAX_RST;
      cfg_r.integral_min <= psc_pkg::INTEGRAL_MIN_RST;
      cfg_r.integral_max <= psc_pkg::INTEGRAL_MAX_RST;
    end else if (wr_en) begin
      case (idx)
        psc_pkg::REG_GAIN_P:       cfg_r.gain_p       <= pwdata[15:0];
        psc_pkg::REG_GAIN_I:       cfg_r.gain_i       <= pwdata[15:0];
        psc_pkg::REG_GAIN_D:       cfg_r.gain_d       <= pwdata[15:0];
        psc_pkg::REG_TARGET_SPEED: cfg_r.target_speed <= pwdata[15:0];
        psc_pkg::REG_DRIVE_MIN:    cfg_r.drive_min    <= pwdata[15:0];
        psc_pkg::REG_DRIVE_MAX:    cfg_r.drive_max    <= pwdata[15:0];
        psc_pkg::REG_INTEGRAL_MIN: cfg_r.integral_min <= pwdata;
        psc_pkg::REG_INTEGRAL_MAX: cfg_r.integral_max <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data returns the sign-extended register value.
  always_comb begin
    case (idx)
      psc_pkg::REG_GAIN_P:       prdata = {{16{cfg_r.gain_p[15]}}, cfg_r.gain_p};
      psc_pkg::REG_GAIN_I:       prdata = {{16{cfg_r.gain_i[15]}}, cfg_r.gain_i};
      psc_pkg::REG_GAIN_D:       prdata = {{16{cfg_r.gain_d[15]}}, cfg_r.gain_d};
      psc_pkg::REG_TARGET_SPEED: prdata = {{16{cfg_r.target_speed[15]}}, cfg_r.target_speed};
      psc_pkg::REG_DRIVE_MIN:    prdata = {{16{cfg_r.drive_min[15]}}, cfg_r.drive_min};
      psc_pkg::REG_DRIVE_MAX:    prdata = {{16{cfg_r.drive_max[15]}}, cfg_r.drive_max};
      psc_pkg::REG_INTEGRAL_MIN: prdata = cfg_r.integral_min;
      psc_pkg::REG_INTEGRAL_MAX: prdata = cfg_r.integral_max;
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: design/pid_speed_controller.sv
`timescale 1ns / 1ps

// PID speed controller with a clamped integral and a clamped derivative.
// Input channel in_ch carries one measured speed sample per transfer; the
// output channel out_ch returns exactly one drive value per sample, in order.
// Gains, setpoint and limits are written over the APB-style cfg_ port; the
// user must write them only while no sample is in flight, as the block does
// not enforce it. Reads return the sign-extended register value.
// Each sample passes the input register, the error/integral/derivative
// register, the multiplier register and the sum and clamp output register.
// Throughput: one sample per cycle while out_ch takes each result. The
// integral and previous error are updated in a single stage, so each sample
// sees the state left by the one before it with no wait.
// Reset (rst_n low, synchronous) empties the pipeline, clears the integral
// and previous error, and loads the register defaults.
// When the receiver stalls, the result waits in the output register and the
// stages behind it keep filling; in_ch.ready falls only once every stage holds
// a sample.
module pid_speed_controller #(
  parameter int DERIV_LIMIT = psc_pkg::DERIV_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  psc_in_if.sink                        in_ch,
  psc_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [psc_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [psc_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int DERIV_W = $clog2(DERIV_LIMIT + 1) + 1;
  localparam int DRAW_W  = psc_pkg::ERR_W + 1;
  localparam int PP_W    = psc_pkg::GAIN_W + psc_pkg::ERR_W;
  localparam int IP_W    = psc_pkg::GAIN_W + psc_pkg::INTEG_W;
  localparam int DP_W    = psc_pkg::GAIN_W + DERIV_W;
  localparam int Q_W     = psc_pkg::SUM_W - psc_pkg::FRAC_W;
  localparam logic signed [DRAW_W-1:0] DLIM_POS = DRAW_W'(DERIV_LIMIT);
  localparam logic signed [DRAW_W-1:0] DLIM_NEG = -DLIM_POS;

  psc_pkg::cfg_t cfg;

  psc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Pipeline control
  logic s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic s0_ready, s1_ready, s2_ready, s3_ready;
  logic s0_adv, s1_adv, s2_adv;

  // Stage data
  logic signed [psc_pkg::SPEED_W-1:0] meas_r;
  logic signed [psc_pkg::ERR_W-1:0]   err_r;
  logic signed [psc_pkg::INTEG_W-1:0] integ_r;
  logic signed [DERIV_W-1:0]          deriv_r;
  logic signed [PP_W-1:0]             p_prod_r;
  logic signed [IP_W-1:0]             i_prod_r;
  logic signed [DP_W-1:0]             d_prod_r;
  logic signed [psc_pkg::SPEED_W-1:0] drive_r;

  // Controller state
  logic signed [psc_pkg::INTEG_W-1:0] integ_state_r, integ_state_nxt;
  logic signed [psc_pkg::ERR_W-1:0]   prev_err_r, prev_err_nxt;

  // Stage 1 combinational values
  logic signed [psc_pkg::ERR_W-1:0]   err;
  logic signed [psc_pkg::INTEG_W:0]   acc;
  logic signed [DRAW_W-1:0]           deriv_raw;
  logic signed [DRAW_W-1:0]           deriv_cl;

  // Stage 3 combinational values
  logic signed [psc_pkg::SUM_W-1:0]   sum;
  logic signed [psc_pkg::SUM_W-1:0]   sum_biased;
  logic signed [Q_W-1:0]              quot;
  logic signed [psc_pkg::SPEED_W-1:0] drive_nxt;

  // A stage takes new data when it is empty or its content moves on.
  assign s3_ready = !out_valid_r || out_ch.ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign s0_adv   = s0_valid_r && s1_ready;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign s2_adv   = s2_valid_r && s3_ready;

  assign in_ch.ready        = s0_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_ch.valid && s0_ready) begin
      meas_r <= in_ch.measured_speed;
    end
  end

  // Sign extension of a speed value to the error width.
  function automatic logic signed [psc_pkg::ERR_W-1:0] ERR_W_EXT(
    input logic signed [psc_pkg::SPEED_W-1:0] v
  );
    return psc_pkg::ERR_W'(v);
  endfunction

  // Error, clamped integral and clamped derivative.
  always_comb begin
    err       = ERR_W_EXT(cfg.target_speed) - ERR_W_EXT(meas_r);
    acc       = (psc_pkg::INTEG_W + 1)'(integ_state_r) + (psc_pkg::INTEG_W + 1)'(err);
    deriv_raw = DRAW_W'(err) - DRAW_W'(prev_err_r);

    // The upper limit is tested first, so inverted limits favor the maximum.
    if (acc > (psc_pkg::INTEG_W + 1)'(cfg.integral_max)) begin
      integ_state_nxt = cfg.integral_max;
    end else if (acc < (psc_pkg::INTEG_W + 1)'(cfg.integral_min)) begin
      integ_state_nxt = cfg.integral_min;
    end else begin
      integ_state_nxt = acc[psc_pkg::INTEG_W-1:0];
    end

    if (deriv_raw > DLIM_POS) begin
      deriv_cl = DLIM_POS;
    end else if (deriv_raw < DLIM_NEG) begin
      deriv_cl = DLIM_NEG;
    end else begin
      deriv_cl = deriv_raw;
    end

    prev_err_nxt = err;
  end

  // Controller state moves with each sample leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_state_r <= '0;
      prev_err_r    <= '0;
    end else if (s0_adv) begin
      integ_state_r <= integ_state_nxt;
      prev_err_r    <= prev_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      err_r   <= err;
      integ_r <= integ_state_nxt;
      deriv_r <= deriv_cl[DERIV_W-1:0];
    end
  end

  // Three gain multipliers, one per term.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      p_prod_r <= PP_W'(cfg.gain_p) * PP_W'(err_r);
      i_prod_r <= IP_W'(cfg.gain_i) * IP_W'(integ_r);
      d_prod_r <= DP_W'(cfg.gain_d) * DP_W'(deriv_r);
    end
  end

  // Sum, divide by 256 toward zero, then clamp to the drive limits.
  always_comb begin
    sum = psc_pkg::SUM_W'(p_prod_r) + psc_pkg::SUM_W'(i_prod_r)
        + psc_pkg::SUM_W'(d_prod_r);
    sum_biased = sum[psc_pkg::SUM_W-1]
               ? sum + psc_pkg::SUM_W'((1 << psc_pkg::FRAC_W) - 1)
               : sum;
    quot = sum_biased[psc_pkg::SUM_W-1:psc_pkg::FRAC_W];

    if (quot > Q_W'(cfg.drive_max)) begin
      drive_nxt = cfg.drive_max;
    end else if (quot < Q_W'(cfg.drive_min)) begin
      drive_nxt = cfg.drive_min;
    end else begin
      drive_nxt = quot[psc_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      drive_r <= drive_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The stored derivative never leaves its bound.
  a_deriv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (DRAW_W'(deriv_r) <= DLIM_POS && DRAW_W'(deriv_r) >= DLIM_NEG))
    else $error("derivative outside its bound");

  // The previous error changes only when a sample enters stage one.
  a_state_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(prev_err_r)) |-> $past(s0_adv))
    else $error("previous error changed without a sample");

  // A result leaves the output register only through a transfer.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(out_valid_r)) |-> $past(out_ch.ready))
    else $error("result dropped without a transfer");

  // A sample in the input register is never overwritten while it waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !s1_ready) |-> !in_ch.ready)
    else $error("input accepted over a waiting sample");
`endif

endmodule

// File: tb/pid_drive_checker.sv
`timescale 1ns / 1ps

// Watches the sample and drive channels and the register port of the speed
// controller. Every sample transfer is run through a local copy of the control
// law, and every drive transfer is compared with the oldest prediction.
module pid_drive_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  psc_in_if                          speed_ch,
  psc_out_if                         drive_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [psc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [psc_pkg::DATA_W-1:0] cfg_pwdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         checked
);

  // Mirror of the register file and of the controller state.
  psc_pkg::cfg_t                      settings;
  logic signed [psc_pkg::INTEG_W-1:0] integral_acc;
  logic signed [psc_pkg::ERR_W-1:0]   last_error;
  logic signed [psc_pkg::SPEED_W-1:0] drive_fifo[$];
  int                                 err_count = 0;
  int                                 done_count = 0;

  // One control step: updates the mirrored state and returns the drive value.
  function automatic logic signed [psc_pkg::SPEED_W-1:0] next_drive(
    input logic signed [psc_pkg::SPEED_W-1:0] speed
  );
    longint err;
    longint acc;
    longint slope;
    longint total;
    longint drive;
    err = longint'(settings.target_speed) - longint'(speed);

    // Integral with anti-windup; the upper limit is tested first.
    acc = longint'(integral_acc) + err;
    if (acc > longint'(settings.integral_max)) begin
      acc = longint'(settings.integral_max);
    end else if (acc < longint'(settings.integral_min)) begin
      acc = longint'(settings.integral_min);
    end
    integral_acc = acc[psc_pkg::INTEG_W-1:0];

    // Derivative, bounded on both sides.
    slope = err - longint'(last_error);
    if (slope > longint'(psc_pkg::DERIV_LIMIT_DEF)) begin
      slope = longint'(psc_pkg::DERIV_LIMIT_DEF);
    end
    if (slope < -longint'(psc_pkg::DERIV_LIMIT_DEF)) begin
      slope = -longint'(psc_pkg::DERIV_LIMIT_DEF);
    end
    last_error = err[psc_pkg::ERR_W-1:0];

    // Weighted sum in Q.8, truncated toward zero, then clamped.
    total = longint'(settings.gain_p) * err
          + longint'(settings.gain_i) * acc
          + longint'(settings.gain_d) * slope;
    drive = total / 256;
    if (drive > longint'(settings.drive_max)) begin
      drive = longint'(settings.drive_max);
    end else if (drive < longint'(settings.drive_min)) begin
      drive = longint'(settings.drive_min);
    end
    return drive[psc_pkg::SPEED_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [psc_pkg::SPEED_W-1:0] want;
    if (!rst_n) begin
      settings.gain_p       = '0;
      settings.gain_i       = '0;
      settings.gain_d       = '0;
      settings.target_speed = '0;
      settings.drive_min    = psc_pkg::DRIVE_MIN_RST;
      settings.drive_max    = psc_pkg::DRIVE_MAX_RST;
      settings.integral_min = psc_pkg::INTEGRAL_MIN_RST;
      settings.integral_max = psc_pkg::INTEGRAL_MAX_RST;
      integral_acc          = '0;
      last_error            = '0;
      drive_fifo.delete();
    end else begin
      // Register writes complete at the access phase.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (psc_pkg::reg_idx_t'(cfg_paddr[psc_pkg::ADDR_W-1:2]))
          psc_pkg::REG_GAIN_P:
            settings.gain_p       = cfg_pwdata[psc_pkg::GAIN_W-1:0];
          psc_pkg::REG_GAIN_I:
            settings.gain_i       = cfg_pwdata[psc_pkg::GAIN_W-1:0];
          psc_pkg::REG_GAIN_D:
            settings.gain_d       = cfg_pwdata[psc_pkg::GAIN_W-1:0];
          psc_pkg::REG_TARGET_SPEED:
            settings.target_speed = cfg_pwdata[psc_pkg::SPEED_W-1:0];
          psc_pkg::REG_DRIVE_MIN:
            settings.drive_min    = cfg_pwdata[psc_pkg::SPEED_W-1:0];
          psc_pkg::REG_DRIVE_MAX:
            settings.drive_max    = cfg_pwdata[psc_pkg::SPEED_W-1:0];
          psc_pkg::REG_INTEGRAL_MIN:
            settings.integral_min = cfg_pwdata[psc_pkg::INTEG_W-1:0];
          psc_pkg::REG_INTEGRAL_MAX:
            settings.integral_max = cfg_pwdata[psc_pkg::INTEG_W-1:0];
          default: ;
        endcase
      end

      // Compare each drive transfer with the oldest prediction.
      if (drive_ch.valid && drive_ch.ready) begin
        if (drive_fifo.size() == 0) begin
          err_count++;
          $display("%0t: drive_value transfer with none pending: expected none, actual %0d",
                   $time, drive_ch.drive_value);
        end else begin
          want = drive_fifo.pop_front();
          done_count++;
          if (drive_ch.drive_value !== want) begin
            err_count++;
            $display("%0t: drive_value mismatch: expected %0d, actual %0d",
                     $time, want, drive_ch.drive_value);
          end
        end
      end

      // Each accepted sample yields exactly one drive value.
      if (speed_ch.valid && speed_ch.ready) begin
        drive_fifo.push_back(next_drive(speed_ch.measured_speed));
      end
    end
    mismatches  <= err_count;
    outstanding <= drive_fifo.size();
    checked     <= done_count;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PERCENT = 17;
  localparam int TAIL_CYCLES  = 20;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [psc_pkg::ADDR_W-1:0] cfg_paddr;
  logic [psc_pkg::DATA_W-1:0] cfg_pwdata;
  logic [psc_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;
  logic                       calm;
  int                         mismatches;
  int                         outstanding;
  int                         checked;
  int                         cycle_count = 0;
  int                         sample_count = 0;
  int                         setting_count = 0;

  psc_in_if  speed_ch ();
  psc_out_if drive_ch ();

  pid_speed_controller DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (speed_ch),
    .out_ch      (drive_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pid_drive_checker drive_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .speed_ch    (speed_ch),
    .drive_ch    (drive_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The drive receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    drive_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d drive values pending",
               cycle_count, outstanding);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [psc_pkg::DATA_W-1:0] widen16(input logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic psc_pkg::cfg_t make_settings(input int gp, input int gi, input int gd,
                                                  input int tgt, input int dmin,
                                                  input int dmax, input int imin,
                                                  input int imax);
    psc_pkg::cfg_t s;
    s.gain_p       = gp[15:0];
    s.gain_i       = gi[15:0];
    s.gain_d       = gd[15:0];
    s.target_speed = tgt[15:0];
    s.drive_min    = dmin[15:0];
    s.drive_max    = dmax[15:0];
    s.integral_min = imin;
    s.integral_max = imax;
    return s;
  endfunction

  // Half of the gains are small so the drive often stays inside its limits.
  function automatic logic signed [15:0] random_gain();
    if ($urandom_range(1) == 0) begin
      return 16'(int'($urandom_range(0, 1023)) - 512);
    end
    return 16'($urandom);
  endfunction

  function automatic psc_pkg::cfg_t random_settings();
    psc_pkg::cfg_t       s;
    logic signed [15:0]  a;
    logic signed [15:0]  b;
    logic signed [31:0]  c;
    logic signed [31:0]  d;
    int                  pick;
    int                  span;
    s.gain_p       = random_gain();
    s.gain_i       = random_gain();
    s.gain_d       = random_gain();
    s.target_speed = 16'($urandom);

    // Drive limits: full range, ordered random, or inverted.
    a    = 16'($urandom);
    b    = 16'($urandom);
    pick = $urandom_range(9);
    if (pick < 2) begin
      a = 16'h8000;
      b = 16'h7FFF;
    end else if (pick < 9) begin
      if (a > b) {a, b} = {b, a};
    end else begin
      if (a < b) {a, b} = {b, a};
    end
    s.drive_min = a;
    s.drive_max = b;

    // Integral limits: small symmetric, full range, ordered random, or inverted.
    c    = 32'($urandom);
    d    = 32'($urandom);
    pick = $urandom_range(9);
    if (pick < 3) begin
      span = $urandom_range(0, 5000);
      c    = -span;
      d    = span;
    end else if (pick < 5) begin
      c = 32'h8000_0000;
      d = 32'h7FFF_FFFF;
    end else if (pick < 9) begin
      if (c > d) {c, d} = {d, c};
    end else begin
      if (c < d) {c, d} = {d, c};
    end
    s.integral_min = c;
    s.integral_max = d;
    return s;
  endfunction

  // Mostly samples close to the setpoint, the rest anywhere in range.
  function automatic logic signed [15:0] random_speed(input logic signed [15:0] tgt);
    if ($urandom_range(99) < 60) begin
      return tgt + 16'(int'($urandom_range(0, 160)) - 80);
    end
    return 16'($urandom);
  endfunction

  // One register write: setup phase, then access phase until pready.
  task automatic write_reg(input psc_pkg::reg_idx_t idx,
                           input logic [psc_pkg::DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic load_settings(input psc_pkg::cfg_t s);
    write_reg(psc_pkg::REG_GAIN_P, widen16(s.gain_p));
    write_reg(psc_pkg::REG_GAIN_I, widen16(s.gain_i));
    write_reg(psc_pkg::REG_GAIN_D, widen16(s.gain_d));
    write_reg(psc_pkg::REG_TARGET_SPEED, widen16(s.target_speed));
    write_reg(psc_pkg::REG_DRIVE_MIN, widen16(s.drive_min));
    write_reg(psc_pkg::REG_DRIVE_MAX, widen16(s.drive_max));
    write_reg(psc_pkg::REG_INTEGRAL_MIN, s.integral_min);
    write_reg(psc_pkg::REG_INTEGRAL_MAX, s.integral_max);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    setting_count++;
  endtask

  // Offers one sample, with a random gap in front, and waits for its transfer.
  task automatic send_speed(input logic signed [15:0] speed);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      speed_ch.valid <= 1'b0;
      @(posedge clk);
    end
    speed_ch.valid          <= 1'b1;
    speed_ch.measured_speed <= speed;
    @(posedge clk);
    while (!speed_ch.ready) @(posedge clk);
    sample_count++;
  endtask

  // Stops offering samples and waits until every drive value has come back.
  task automatic drain();
    speed_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    psc_pkg::cfg_t s;
    rst_n                   <= 1'b0;
    calm                    <= 1'b0;
    speed_ch.valid          <= 1'b0;
    speed_ch.measured_speed <= '0;
    cfg_psel                <= 1'b0;
    cfg_penable             <= 1'b0;
    cfg_pwrite              <= 1'b0;
    cfg_paddr               <= '0;
    cfg_pwdata              <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unity gains: zero error, full-scale steps and both derivative bounds.
    load_settings(make_settings(256, 256, 256, 0, -32768, 32767, -1000, 1000));
    send_speed(16'sd0);
    send_speed(16'sd32767);
    send_speed(16'h8000);
    send_speed(16'sd1);
    send_speed(-16'sd1);
    send_speed(16'sd0);
    drain();

    // Extreme gains, setpoint and integral limits.
    load_settings(make_settings(32767, -32768, -32768, 32767, -32768, 32767,
                                32'h8000_0000, 32'h7FFF_FFFF));
    send_speed(16'h8000);
    send_speed(16'h8000);
    send_speed(16'sd32767);
    send_speed(16'sd0);
    send_speed(16'sd32767);
    drain();

    // Inverted integral and drive limits with fractional gains.
    load_settings(make_settings(128, -64, 384, -5, 20, -20, 10, -10));
    send_speed(-16'sd5);
    send_speed(-16'sd2);
    send_speed(-16'sd8);
    send_speed(16'sd3);
    send_speed(-16'sd100);
    send_speed(16'sd50);
    drain();

    // Half gain on odd errors shows truncation toward zero.
    load_settings(make_settings(128, 0, 0, 0, -32768, 32767, -1000, 1000));
    send_speed(16'sd3);
    send_speed(-16'sd3);
    send_speed(16'sd1);
    send_speed(-16'sd1);
    drain();

    // Random phases; the last one returns to the reset limits.
    for (int ph = 0; ph < 7; ph++) begin
      s = random_settings();
      if (ph == 6) begin
        s.drive_min    = psc_pkg::DRIVE_MIN_RST;
        s.drive_max    = psc_pkg::DRIVE_MAX_RST;
        s.integral_min = psc_pkg::INTEGRAL_MIN_RST;
        s.integral_max = psc_pkg::INTEGRAL_MAX_RST;
      end
      calm <= (ph == 3);
      load_settings(s);
      repeat (100) send_speed(random_speed(s.target_speed));
      drain();
    end
    calm <= 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d speed samples under %0d register settings.",
             sample_count, setting_count);
    $display("Checked %0d drive values; %0d mismatches; %0d still pending.",
             checked, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
